[rtl/core/txu_pkg.sv]
// shared types, opcodes, status codes and data store preset for the execute unit
`default_nettype none

package txu_pkg;

   localparam logic [7:0] OP_ADD   = 8'd1;
   localparam logic [7:0] OP_SUB   = 8'd3;
   localparam logic [7:0] OP_OR    = 8'd4;
   localparam logic [7:0] OP_AND   = 8'd5;
   localparam logic [7:0] OP_LOAD  = 8'd8;
   localparam logic [7:0] OP_STORE = 8'd9;

   localparam int unsigned TARGET_BITS = 16;
   localparam int unsigned VALUE_BITS  = 32;
   localparam int unsigned PRESET_BITS = 32;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_UNKNOWN  = 2'd1,
      ST_BAD_REG  = 2'd2,
      ST_BAD_ADDR = 2'd3
   } status_type;

   typedef struct packed {
      logic                   reg_wr;
      logic                   mem_wr;
      logic [TARGET_BITS-1:0] target;
      status_type             status;
   } result_ctl_type;

   function automatic logic [PRESET_BITS-1:0] preset_word(input logic [TARGET_BITS-1:0] idx);
      logic [PRESET_BITS-1:0] word;
      word = '0;
      unique case (idx)
         16'd0:   word = 32'd1;
         16'd1:   word = 32'd2;
         16'd4:   word = 32'd3328;
         16'd5:   word = 32'd15360;
         default: word = '0;
      endcase
      return word;
   endfunction

endpackage

`default_nettype wire

[rtl/core/txu_ram.sv]
// generic single write port, single read port ram with registered read data
`default_nettype none

module txu_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/txu_exec.sv]
// instruction decode, range checks and alu for one instruction
`default_nettype none

module txu_exec
   import txu_pkg::*;
#(
   parameter int unsigned REG_COUNT  = 10,
   parameter int unsigned DATA_WORDS = 8,
   parameter int unsigned WORD_BITS  = 32
) (
   input  wire logic [31:0]          instr,
   input  wire logic [WORD_BITS-1:0] src_a,
   input  wire logic [WORD_BITS-1:0] src_b,
   input  wire logic [WORD_BITS-1:0] load_data,
   output result_ctl_type            ctl,
   output logic      [WORD_BITS-1:0] value
);

   logic [7:0]             op;
   logic [7:0]             r1;
   logic [7:0]             r2;
   logic [7:0]             r3;
   logic [TARGET_BITS-1:0] addr;
   logic                   r1_ok;
   logic                   r2_ok;
   logic                   r3_ok;
   logic                   addr_ok;
   logic [WORD_BITS-1:0]   alu_res;

   assign op   = instr[7:0];
   assign r1   = instr[15:8];
   assign r2   = instr[23:16];
   assign r3   = instr[31:24];
   assign addr = instr[31:16];

   assign r1_ok   = {1'b0, r1} < 9'(REG_COUNT);
   assign r2_ok   = {1'b0, r2} < 9'(REG_COUNT);
   assign r3_ok   = {1'b0, r3} < 9'(REG_COUNT);
   assign addr_ok = {1'b0, addr} < 17'(DATA_WORDS);

   always_comb begin
      unique case (op)
         OP_ADD:  alu_res = src_a + src_b;
         OP_SUB:  alu_res = src_a - src_b;
         OP_OR:   alu_res = src_a | src_b;
         default: alu_res = src_a & src_b;
      endcase
   end

   always_comb begin
      ctl.reg_wr = 1'b0;
      ctl.mem_wr = 1'b0;
      ctl.target = '0;
      ctl.status = ST_UNKNOWN;
      value      = '0;
      unique case (op)
         OP_ADD, OP_SUB, OP_OR, OP_AND: begin
            if (r1_ok && r2_ok && r3_ok) begin
               ctl.status = ST_OK;
               ctl.reg_wr = 1'b1;
               ctl.target = TARGET_BITS'(r3);
               value      = alu_res;
            end else begin
               ctl.status = ST_BAD_REG;
            end
         end
         OP_LOAD, OP_STORE: begin
            // bad register index takes precedence over bad address
            if (!r1_ok) begin
               ctl.status = ST_BAD_REG;
            end else if (!addr_ok) begin
               ctl.status = ST_BAD_ADDR;
            end else if (op == OP_LOAD) begin
               ctl.status = ST_OK;
               ctl.reg_wr = 1'b1;
               ctl.target = TARGET_BITS'(r1);
               value      = load_data;
            end else begin
               ctl.status = ST_OK;
               ctl.mem_wr = 1'b1;
               ctl.target = addr;
               value      = src_b;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/toy_isa_execute_unit.sv]
// execute unit: register file read at accept, execute stage, registered result beat
// an instruction is registered into the execute stage, then into the result register;
// one instruction per cycle unless rsp_tready or the preset stalls; operands come from
// ram reads launched at accept, bypassing the write that retires on the same clock edge
// reset: after reset the data store preset fills all DATA_WORDS words with req_tready low;
// the register file reads as zero until each entry is first written
`default_nettype none

module toy_isa_execute_unit
   import txu_pkg::*;
#(
   parameter int unsigned REG_COUNT  = 10,
   parameter int unsigned DATA_WORDS = 8,
   parameter int unsigned WORD_BITS  = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // instr_word
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [47:0] rsp_tdata,   // target_index, write_value
   output logic      [3:0]  rsp_tuser    // reg_written, mem_written, status
);

   localparam int unsigned RIW = $clog2(REG_COUNT);
   localparam int unsigned DAW = DATA_WORDS > 1 ? $clog2(DATA_WORDS) : 1;

   // data store preset pass
   logic           init_busy_ff, init_busy_in;
   logic [DAW-1:0] init_cnt_ff, init_cnt_in;
   logic [WORD_BITS+PRESET_BITS-1:0] preset_ext;

   // execute stage
   logic                 x_valid_ff, x_valid_in;
   logic [31:0]          x_instr_ff;
   logic                 a_vld_ff;
   logic                 b_vld_ff;
   logic                 byp_rf_ff;
   logic [RIW-1:0]       byp_rf_addr_ff;
   logic [WORD_BITS-1:0] byp_rf_data_ff;
   logic                 byp_dm_ff;
   logic [DAW-1:0]       byp_dm_addr_ff;
   logic [WORD_BITS-1:0] byp_dm_data_ff;

   // result stage
   logic                  r_valid_ff, r_valid_in;
   result_ctl_type        r_ctl_ff;
   logic [VALUE_BITS-1:0] r_value_ff;
   logic [WORD_BITS+VALUE_BITS-1:0] value_ext;

   logic                 accept;
   logic                 r_ready;
   logic                 x_advance;
   logic [RIW-1:0]       rd_addr_a;
   logic [RIW-1:0]       rd_addr_b;
   logic [DAW-1:0]       rd_addr_d;
   logic [WORD_BITS-1:0] ram_a;
   logic [WORD_BITS-1:0] ram_b;
   logic [WORD_BITS-1:0] ram_d;
   logic [WORD_BITS-1:0] src_a;
   logic [WORD_BITS-1:0] src_b;
   logic [WORD_BITS-1:0] load_data;
   result_ctl_type       x_ctl;
   logic [WORD_BITS-1:0] x_value;
   logic                 rf_we;
   logic [RIW-1:0]       rf_wr_addr;
   logic                 dm_exec_we;
   logic                 dm_we;
   logic [DAW-1:0]       dm_wr_addr;
   logic [WORD_BITS-1:0] dm_wr_data;
   logic [REG_COUNT-1:0] rf_valid_ff, rf_valid_in;

   assign r_ready    = !r_valid_ff || rsp_tready;
   assign x_advance  = x_valid_ff && r_ready;
   assign req_tready = !init_busy_ff && (!x_valid_ff || r_ready);
   assign accept     = req_tvalid && req_tready;

   assign rd_addr_a = req_tdata[16 +: RIW];
   assign rd_addr_b = req_tdata[8 +: RIW];
   assign rd_addr_d = req_tdata[16 +: DAW];

   // write ports, both retire when the execute stage moves on
   assign rf_we      = x_advance && x_ctl.reg_wr;
   assign rf_wr_addr = x_ctl.target[RIW-1:0];
   assign dm_exec_we = x_advance && x_ctl.mem_wr;
   assign preset_ext = {{WORD_BITS{1'b0}}, preset_word(TARGET_BITS'(init_cnt_ff))};
   assign dm_we      = init_busy_ff || dm_exec_we;
   assign dm_wr_addr = init_busy_ff ? init_cnt_ff : x_ctl.target[DAW-1:0];
   assign dm_wr_data = init_busy_ff ? preset_ext[WORD_BITS-1:0] : x_value;

   txu_ram #(.WIDTH(WORD_BITS), .DEPTH(REG_COUNT)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_wr_addr),
      .wr_data (x_value),
      .rd_en   (accept),
      .rd_addr (rd_addr_a),
      .rd_data (ram_a)
   );

   txu_ram #(.WIDTH(WORD_BITS), .DEPTH(REG_COUNT)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_wr_addr),
      .wr_data (x_value),
      .rd_en   (accept),
      .rd_addr (rd_addr_b),
      .rd_data (ram_b)
   );

   txu_ram #(.WIDTH(WORD_BITS), .DEPTH(DATA_WORDS)) u_dm (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_wr_addr),
      .wr_data (dm_wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr_d),
      .rd_data (ram_d)
   );

   // forward the write that retired on the accepting edge; unwritten registers read zero
   always_comb begin
      if (byp_rf_ff && byp_rf_addr_ff == x_instr_ff[16 +: RIW]) begin
         src_a = byp_rf_data_ff;
      end else begin
         src_a = a_vld_ff ? ram_a : '0;
      end
      if (byp_rf_ff && byp_rf_addr_ff == x_instr_ff[8 +: RIW]) begin
         src_b = byp_rf_data_ff;
      end else begin
         src_b = b_vld_ff ? ram_b : '0;
      end
      if (byp_dm_ff && byp_dm_addr_ff == x_instr_ff[16 +: DAW]) begin
         load_data = byp_dm_data_ff;
      end else begin
         load_data = ram_d;
      end
   end

   txu_exec #(
      .REG_COUNT  (REG_COUNT),
      .DATA_WORDS (DATA_WORDS),
      .WORD_BITS  (WORD_BITS)
   ) u_exec (
      .instr     (x_instr_ff),
      .src_a     (src_a),
      .src_b     (src_b),
      .load_data (load_data),
      .ctl       (x_ctl),
      .value     (x_value)
   );

   assign value_ext = {{VALUE_BITS{1'b0}}, x_value};

   always_comb begin
      init_busy_in = init_busy_ff;
      init_cnt_in  = init_cnt_ff;
      if (init_busy_ff) begin
         if (init_cnt_ff == DAW'(DATA_WORDS - 1)) begin
            init_busy_in = 1'b0;
         end else begin
            init_cnt_in = init_cnt_ff + 1'b1;
         end
      end

      x_valid_in = accept || (x_valid_ff && !r_ready);
      r_valid_in = x_advance || (r_valid_ff && !rsp_tready);

      rf_valid_in = rf_valid_ff;
      if (rf_we) begin
         rf_valid_in[rf_wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_busy_ff <= 1'b1;
         init_cnt_ff  <= '0;
         x_valid_ff   <= 1'b0;
         r_valid_ff   <= 1'b0;
         rf_valid_ff  <= '0;
      end else begin
         init_busy_ff <= init_busy_in;
         init_cnt_ff  <= init_cnt_in;
         x_valid_ff   <= x_valid_in;
         r_valid_ff   <= r_valid_in;
         rf_valid_ff  <= rf_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_instr_ff     <= req_tdata;
         a_vld_ff       <= rf_valid_ff[rd_addr_a];
         b_vld_ff       <= rf_valid_ff[rd_addr_b];
         byp_rf_ff      <= rf_we;
         byp_rf_addr_ff <= rf_wr_addr;
         byp_rf_data_ff <= x_value;
         byp_dm_ff      <= dm_exec_we;
         byp_dm_addr_ff <= x_ctl.target[DAW-1:0];
         byp_dm_data_ff <= x_value;
      end
      if (x_advance) begin
         r_ctl_ff   <= x_ctl;
         r_value_ff <= value_ext[VALUE_BITS-1:0];
      end
   end

   assign rsp_tvalid = r_valid_ff;
   assign rsp_tdata  = {r_value_ff, r_ctl_ff.target};
   assign rsp_tuser  = {r_ctl_ff.status, r_ctl_ff.mem_wr, r_ctl_ff.reg_wr};

`ifndef ASSERT_OFF
   // no instruction may enter while the data store preset is still running
   a_no_accept_in_init: assert property (@(posedge clock) disable iff (reset)
      init_busy_ff |-> !accept)
      else $error("instruction accepted during data store preset");

   // an instruction writes at most one of the two stores
   a_single_store_write: assert property (@(posedge clock) disable iff (reset)
      !(rf_we && dm_exec_we))
      else $error("register file and data store written by one instruction");

   // a flagged instruction never commits a write
   a_no_write_on_error: assert property (@(posedge clock) disable iff (reset)
      (x_advance && x_ctl.status != ST_OK) |-> (!rf_we && !dm_exec_we))
      else $error("write committed by a flagged instruction");

   // the execute stage only moves on into a free or draining result register
   a_result_not_lost: assert property (@(posedge clock) disable iff (reset)
      (r_valid_ff && !rsp_tready) |=> (r_valid_ff && $stable(r_ctl_ff)))
      else $error("pending result beat overwritten");
`endif

endmodule

`default_nettype wire
